/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL. Every macro samples on the rising edge of clk_i and is
// switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition in one cycle that must be followed by a consequence in the next cycle.
`define ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/b64e_pkg.sv */
package b64e_pkg;

  localparam int unsigned NumWords = 8;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [7:0] PadChar = 8'd61;

  // One encode job: up to four character slots, played out from slot 0 to last_slot.
  typedef struct packed {
    logic [1:0]      last_slot;
    logic            fin;
    logic [3:0]      pad;
    logic [3:0][5:0] idx;
  } job_t;

  // Queue occupancy as seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* rtl/b64e_front.sv */
module b64e_front import b64e_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       is_final_byte_i,
  input  q_stat_t    q_stat_i,
  output logic       push_o,
  output job_t       job_o,
  output logic [1:0] group_pos_o
);

  logic [1:0] pos_q, pos_d;
  logic [3:0] left_q, left_d;

  assign in_ready_o  = !q_stat_i.full;
  assign push_o      = in_valid_i && in_ready_o;
  assign group_pos_o = pos_q;

  // Split the byte into six-bit indices according to its place in the group.
  always_comb begin
    job_o     = '0;
    job_o.fin = is_final_byte_i;
    pos_d     = pos_q;
    left_d    = left_q;
    case (pos_q)
      2'd1: begin
        job_o.idx[0] = {left_q[1:0], data_byte_i[7:4]};
        job_o.idx[1] = {data_byte_i[3:0], 2'b00};
        if (is_final_byte_i) begin
          job_o.last_slot = 2'd2;
          job_o.pad       = 4'b0100;
        end
        left_d = data_byte_i[3:0];
        pos_d  = 2'd2;
      end
      2'd2: begin
        job_o.idx[0]    = {left_q, data_byte_i[7:6]};
        job_o.idx[1]    = data_byte_i[5:0];
        job_o.last_slot = 2'd1;
        left_d          = '0;
        pos_d           = 2'd0;
      end
      default: begin
        job_o.idx[0] = data_byte_i[7:2];
        job_o.idx[1] = {data_byte_i[1:0], 4'b0000};
        if (is_final_byte_i) begin
          job_o.last_slot = 2'd3;
          job_o.pad       = 4'b1100;
        end
        left_d = {2'b00, data_byte_i[1:0]};
        pos_d  = 2'd1;
      end
    endcase
    if (is_final_byte_i) begin
      pos_d  = 2'd0;
      left_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      left_q <= '0;
    end else if (push_o) begin
      pos_q  <= pos_d;
      left_q <= left_d;
    end
  end

endmodule

/* rtl/b64e_queue.sv */
module b64e_queue import b64e_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  job_t    push_job_i,
  input  logic    pop_i,
  output job_t    head_o,
  output q_stat_t stat_o
);

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* rtl/b64e_back.sv */
module b64e_back import b64e_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  job_t               head_i,
  input  q_stat_t            q_stat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_char_o,
  output logic               end_of_run_o,
  output logic               end_of_message_o
);

  logic [NumWords-1:0][7:0][7:0] alpha_q;
  logic [1:0]                    slot_q;
  logic                          valid_q;
  logic [7:0]                    char_q;
  logic                          eor_q, eom_q;
  logic                          advance;
  logic [5:0]                    cur_idx;
  logic [7:0]                    cur_char;

  assign advance  = !q_stat_i.empty && (!valid_q || out_ready_i);
  assign pop_o    = advance && (slot_q == head_i.last_slot);
  assign cur_idx  = head_i.idx[slot_q];
  assign cur_char = head_i.pad[slot_q] ? PadChar : alpha_q[cur_idx[5:3]][cur_idx[2:0]];

  assign out_valid_o      = valid_q;
  assign out_char_o       = char_q;
  assign end_of_run_o     = eor_q;
  assign end_of_message_o = eom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= '0;
    end else if (cfg_valid_i && (cfg_index_i < CfgIdxW'(NumWords))) begin
      alpha_q[cfg_index_i[$clog2(NumWords)-1:0]] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (advance) begin
        slot_q  <= pop_o ? 2'd0 : slot_q + 1'b1;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      char_q <= cur_char;
      eor_q  <= pop_o;
      eom_q  <= pop_o && head_i.fin;
    end
  end

endmodule

/* rtl/base64_encoder_custom_alphabet.sv */
// Streaming Base64 encoder with an alphabet that software loads.
// Input channel: one raw byte per transfer on data_byte_i, with is_final_byte_i high on the
// last byte of a message. Output channel: one character per transfer on out_char_o;
// end_of_run_o marks the last character caused by an input byte, end_of_message_o the
// last character of the message, after any '=' padding.
// Configuration channel: eight 64-bit alphabet words, index 0 to 7, character 8w+k in
// byte k of word w. Writes to other indices are dropped. cfg_ready_o is always high.
// Each byte's job passes through the job queue; the back end looks its characters up
// and registers them in its output register, from which they transfer.
// Throughput: one character per cycle on the output while jobs wait and the receiver is
// ready, set by the single lookup and output register of the back end. A byte yields one
// or two characters, a final byte up to four, so three bytes of a group yield four.
// Reset clears the group position, the leftover bits, the job queue and the alphabet
// (every character then reads as zero until the words are written).
// When the receiver stalls, the output register holds its character, the two-entry job
// queue fills, and in_ready_o falls once it is full.
`include "assert_macros.svh"

module base64_encoder_custom_alphabet import b64e_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               is_final_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_char_o,
  output logic               end_of_run_o,
  output logic               end_of_message_o
);

  job_t       push_job, head_job;
  logic       push, pop;
  q_stat_t    q_stat;
  logic [1:0] group_pos;

  // Configuration is always taken at once; the alphabet sits in the back end.
  assign cfg_ready_o = 1'b1;

  // The front end splits each byte into the six-bit indices it completes and keeps the
  // position within the three-byte group.
  b64e_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .data_byte_i,
    .is_final_byte_i,
    .q_stat_i    (q_stat),
    .push_o      (push),
    .job_o       (push_job),
    .group_pos_o (group_pos)
  );

  // A short queue of jobs decouples byte intake from character output.
  b64e_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .stat_o     (q_stat)
  );

  // The back end plays each job out one character per cycle through the alphabet while the receiver takes them.
  b64e_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .head_i     (head_job),
    .q_stat_i   (q_stat),
    .pop_o      (pop),
    .out_valid_o,
    .out_ready_i,
    .out_char_o,
    .end_of_run_o,
    .end_of_message_o
  );

  // The final character of a message also closes the run of its byte.
  `ASSERT_ALWAYS(a_eom_ends_run, !(out_valid_o && end_of_message_o) || end_of_run_o, "lone eom")
  // A final byte always returns the front end to the start of a group.
  `ASSERT_NEXT(a_final_restarts, push && is_final_byte_i, group_pos == 2'd0, "group not restarted")
  // The group position never reaches three.
  `ASSERT_ALWAYS(a_pos_range, group_pos != 2'd3, "group position out of range")
  // Jobs are only taken from a queue that holds one.
  `ASSERT_ALWAYS(a_no_empty_pop, !(pop && q_stat.empty), "pop from empty queue")

endmodule

/* tb/sv/base64_encoder_custom_alphabet_tb.sv */
module base64_encoder_custom_alphabet_tb;
  import b64e_pkg::*;

  // Register indexes of the configuration channel. The alphabet words sit at
  // AlphaWord0 + w for w in 0 to NumWords-1; everything from NumWords upwards is
  // outside the register file and must be dropped by the block.
  localparam logic [CfgIdxW-1:0] AlphaWord0 = '0;

  // Run control.
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned TailCycles    = 8;
  localparam int unsigned IdlePercent   = 16;
  localparam int unsigned NumRows       = 25;
  localparam int unsigned NumPhases     = 4;
  localparam int unsigned ItemsPerPhase = 80;

  // Alphabets that the run loads. ALPHA_KEEP leaves the loaded alphabet alone.
  typedef enum logic [2:0] {
    ALPHA_KEEP,
    ALPHA_ZERO,
    ALPHA_STD,
    ALPHA_ONES,
    ALPHA_IDENT,
    ALPHA_RAND
  } alpha_sel_e;

  // One output character as the block should present it.
  typedef struct packed {
    logic [7:0] ch;
    logic       eor;
    logic       eom;
  } char_rec_t;

  // One row of the directed stimulus. Where n_typed is non-zero, the characters in
  // typed (first character leftmost) are what the byte must produce; the run flag
  // then sits on the last of them and the message flag follows the final flag.
  typedef struct packed {
    alpha_sel_e      sel;
    logic [7:0]      data;
    logic            fin;
    logic [2:0]      n_typed;
    logic [0:3][7:0] typed;
  } dir_row_t;

  localparam dir_row_t DirRows [NumRows] = '{
    // Straight out of reset every alphabet character reads as zero, so only the
    // padding is visible.
    '{ALPHA_KEEP,  8'hFF, 1'b1, 3'd4, {8'd0, 8'd0, PadChar, PadChar}},
    '{ALPHA_KEEP,  8'h00, 1'b0, 3'd1, {8'd0, 8'd0, 8'd0, 8'd0}},
    '{ALPHA_KEEP,  8'hFF, 1'b1, 3'd3, {8'd0, 8'd0, PadChar, 8'd0}},
    // The usual alphabet: single-byte messages at both extremes.
    '{ALPHA_STD,   8'h00, 1'b1, 3'd4, "AA=="},
    '{ALPHA_STD,   8'hFF, 1'b1, 3'd4, "/w=="},
    // A final byte that completes its group carries no padding.
    '{ALPHA_KEEP,  8'hFF, 1'b0, 3'd1, "/   "},
    '{ALPHA_KEEP,  8'hFF, 1'b0, 3'd1, "/   "},
    '{ALPHA_KEEP,  8'hFF, 1'b1, 3'd2, "//  "},
    '{ALPHA_KEEP,  8'h4D, 1'b0, 3'd1, "T   "},
    '{ALPHA_KEEP,  8'h61, 1'b0, 3'd1, "W   "},
    '{ALPHA_KEEP,  8'h6E, 1'b1, 3'd2, "Fu  "},
    '{ALPHA_KEEP,  8'h00, 1'b0, 3'd1, "A   "},
    '{ALPHA_KEEP,  8'h00, 1'b0, 3'd1, "A   "},
    '{ALPHA_KEEP,  8'h00, 1'b0, 3'd2, "AA  "},
    '{ALPHA_KEEP,  8'h80, 1'b0, 3'd0, '0},
    '{ALPHA_KEEP,  8'h01, 1'b1, 3'd0, '0},
    // Every alphabet byte at all ones.
    '{ALPHA_ONES,  8'h5A, 1'b1, 3'd4, {8'hFF, 8'hFF, PadChar, PadChar}},
    '{ALPHA_KEEP,  8'hA5, 1'b0, 3'd0, '0},
    '{ALPHA_KEEP,  8'h3C, 1'b0, 3'd0, '0},
    '{ALPHA_KEEP,  8'hC3, 1'b1, 3'd0, '0},
    // Character i is the value i, so each character shows its six-bit index.
    '{ALPHA_IDENT, 8'hFC, 1'b0, 3'd1, {8'd63, 8'd0, 8'd0, 8'd0}},
    '{ALPHA_IDENT, 8'h0F, 1'b1, 3'd3, {8'd0, 8'd60, PadChar, 8'd0}},
    '{ALPHA_KEEP,  8'h12, 1'b0, 3'd0, '0},
    '{ALPHA_KEEP,  8'h34, 1'b0, 3'd0, '0},
    '{ALPHA_KEEP,  8'h56, 1'b1, 3'd0, '0}
  };

  // Alphabet and idling for each phase of the random part. The second phase runs
  // without any idling on either side, and the third writes zeros explicitly.
  localparam alpha_sel_e PhaseSel [NumPhases] = '{ALPHA_RAND, ALPHA_STD, ALPHA_ZERO, ALPHA_RAND};
  localparam logic PhaseIdle [NumPhases] = '{1'b1, 1'b0, 1'b1, 1'b1};

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [63:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         data_byte_i;
  logic               is_final_byte_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [7:0]         out_char_o;
  logic               end_of_run_o;
  logic               end_of_message_o;

  base64_encoder_custom_alphabet u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .is_final_byte_i (is_final_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_char_o      (out_char_o),
    .end_of_run_o    (end_of_run_o),
    .end_of_message_o(end_of_message_o)
  );

  // Our own copy of the encoder: the loaded alphabet, the position of the next byte
  // within its three-byte group and the bits of the previous byte not yet sent.
  logic [63:0] alphabet [NumWords];
  logic [1:0]  enc_pos;
  logic [3:0]  enc_left;

  // Characters still owed by the block, oldest first.
  char_rec_t expected_chars [$];

  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  logic        idle_on;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Watchdog: a correct run finishes far inside this limit, so reaching it means the
  // block has hung or lost characters.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("ERROR: timeout after %0d cycles, %0d characters outstanding", cycle_count,
               expected_chars.size());
      $display("base64_encoder_custom_alphabet: mismatch");
      $finish;
    end
  end

  // The receiver stalls in roughly one cycle out of six while idling is enabled.
  always @(posedge clk_i) begin
    out_ready_i <= !idle_on || ($urandom_range(99) >= IdlePercent);
  end

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("ERROR cycle %0d: %s expected 0x%02h got 0x%02h", cycle_count, what, want, got);
    err_count++;
  endtask

  // Output side. Everything is sampled on the falling edge, after the block and the
  // receiver have driven it, so the transfer at the following rising edge is known
  // without any race.
  always @(negedge clk_i) begin : char_monitor
    char_rec_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected character", 8'h00, out_char_o);
      end else begin
        want = expected_chars.pop_front();
        if (out_char_o !== want.ch)
          report_mismatch("out_char", want.ch, out_char_o);
        if (end_of_run_o !== want.eor)
          report_mismatch("end_of_run", 8'(want.eor), 8'(end_of_run_o));
        if (end_of_message_o !== want.eom)
          report_mismatch("end_of_message", 8'(want.eom), 8'(end_of_message_o));
      end
    end
  end

  function automatic logic [7:0] alpha_char(input logic [5:0] i);
    return alphabet[i[5:3]][{i[2:0], 3'b000} +: 8];
  endfunction

  // Works out the characters one input byte causes and moves the group state on.
  // Position three cannot occur, but would be handled as the start of a group.
  function automatic void encode_byte(input logic [7:0] b, input logic fin,
                                      output char_rec_t recs [4], output int n);
    foreach (recs[i]) recs[i] = '0;
    case (enc_pos)
      2'd1: begin
        recs[0].ch = alpha_char({enc_left[1:0], b[7:4]});
        n = 1;
        enc_left = b[3:0];
        enc_pos = 2'd2;
        if (fin) begin
          recs[1].ch = alpha_char({b[3:0], 2'b00});
          recs[2].ch = PadChar;
          n = 3;
        end
      end
      2'd2: begin
        // The third byte completes the group, so no padding even when final.
        recs[0].ch = alpha_char({enc_left, b[7:6]});
        recs[1].ch = alpha_char(b[5:0]);
        n = 2;
        enc_left = '0;
        enc_pos = 2'd0;
      end
      default: begin
        recs[0].ch = alpha_char(b[7:2]);
        n = 1;
        enc_left = {2'b00, b[1:0]};
        enc_pos = 2'd1;
        if (fin) begin
          recs[1].ch = alpha_char({b[1:0], 4'b0000});
          recs[2].ch = PadChar;
          recs[3].ch = PadChar;
          n = 4;
        end
      end
    endcase
    if (fin) begin
      enc_pos = 2'd0;
      enc_left = '0;
      recs[n-1].eom = 1'b1;
    end
    recs[n-1].eor = 1'b1;
  endfunction

  function automatic logic [63:0] alpha_word(input alpha_sel_e sel, input int unsigned w);
    logic [63:0] word;
    int unsigned i;
    word = '0;
    for (int k = 0; k < 8; k++) begin
      i = 8 * w + k;
      case (sel)
        ALPHA_STD: begin
          if (i < 26) word[8*k +: 8] = 8'(i) + "A";
          else if (i < 52) word[8*k +: 8] = 8'(i - 26) + "a";
          else if (i < 62) word[8*k +: 8] = 8'(i - 52) + "0";
          else if (i == 62) word[8*k +: 8] = "+";
          else word[8*k +: 8] = "/";
        end
        ALPHA_IDENT: word[8*k +: 8] = 8'(i);
        default: ;
      endcase
    end
    if (sel == ALPHA_ONES) word = '1;
    if (sel == ALPHA_RAND) word = {$urandom, $urandom};
    return word;
  endfunction

  // One transfer on the configuration channel. Valid is left high so that writes
  // can follow back to back; the caller lowers it after the last one.
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [63:0] value);
    logic acc;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    acc = 1'b0;
    while (!acc) begin
      @(negedge clk_i);
      acc = cfg_ready_o;
      @(posedge clk_i);
    end
    if (idx < NumWords) alphabet[idx] = value;
  endtask

  // Writes all eight words, plus one stray write above the register file which the
  // block has to ignore.
  task automatic load_alphabet(input alpha_sel_e sel);
    for (int unsigned w = 0; w < NumWords; w++)
      cfg_write(AlphaWord0 + CfgIdxW'(w), alpha_word(sel, w));
    cfg_write(CfgIdxW'($urandom_range((1 << CfgIdxW) - 1, NumWords)), {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offers one byte and waits for its transfer. The characters it must cause are
  // queued on the falling edge before that transfer, so they are always waiting
  // before the first of them can appear.
  task automatic send_byte(input logic [7:0] b, input logic fin, input logic [2:0] n_typed,
                           input logic [0:3][7:0] typed);
    char_rec_t recs [4];
    char_rec_t rec;
    int n;
    logic acc;
    while (idle_on && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    is_final_byte_i <= fin;
    acc = 1'b0;
    while (!acc) begin
      @(negedge clk_i);
      acc = in_ready_o;
      if (acc) begin
        encode_byte(b, fin, recs, n);
        if (n_typed != 0) begin
          for (int i = 0; i < n_typed; i++) begin
            rec.ch  = typed[i];
            rec.eor = (i == n_typed - 1);
            rec.eom = (i == n_typed - 1) && fin;
            expected_chars.push_back(rec);
          end
        end else begin
          for (int i = 0; i < n; i++) expected_chars.push_back(recs[i]);
        end
      end
      @(posedge clk_i);
    end
  endtask

  // Holds the sender back until every owed character has been taken, then lets
  // the back end settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  initial begin : stimulus
    dir_row_t    row;
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    logic [7:0]  b;
    logic        last;

    enc_pos     = '0;
    enc_left    = '0;
    foreach (alphabet[w]) alphabet[w] = '0;
    rst_ni          <= 1'b0;
    idle_on         <= 1'b1;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;
    in_valid_i      <= 1'b0;
    data_byte_i     <= '0;
    is_final_byte_i <= 1'b0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: a new alphabet is only loaded once the block has gone quiet.
    for (int r = 0; r < NumRows; r++) begin
      row = DirRows[r];
      if (row.sel != ALPHA_KEEP) begin
        wait_drained();
        load_alphabet(row.sel);
      end
      send_byte(row.data, row.fin, row.n_typed, row.typed);
    end

    // Random part: messages of random length, mostly short, now and then long,
    // with the bytes leaning towards the two extremes. Each phase ends on a final
    // byte and drains fully before the next alphabet goes in.
    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      idle_on <= PhaseIdle[p];
      load_alphabet(PhaseSel[p]);
      sent = 0;
      while (sent < ItemsPerPhase) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(24, 1) : $urandom_range(7, 1);
        for (int k = 0; k < len && sent < ItemsPerPhase; k++) begin
          pick = $urandom_range(7);
          b = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
          last = (k == len - 1) || (sent == ItemsPerPhase - 1);
          send_byte(b, last, 3'd0, '0);
          sent++;
        end
      end
    end

    wait_drained();
    if (err_count == 0) begin
      $display("base64_encoder_custom_alphabet: match");
    end else begin
      $display("base64_encoder_custom_alphabet: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/b64e_pkg.sv
rtl/b64e_front.sv
rtl/b64e_queue.sv
rtl/b64e_back.sv
rtl/base64_encoder_custom_alphabet.sv
tb/sv/base64_encoder_custom_alphabet_tb.sv
